// ===== src/lg_pkg.sv =====
// Shared types, constants and helper functions for the toroidal Life grid.
package lg_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = 64;
  localparam int ROW_AW     = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
  localparam int BIT_IDX_W  = $clog2(ROW_W);
  localparam int STEP_CNT_W = $clog2(MAX_ROWS + 4);

  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DIM_RESET = 64;
  localparam int MIN_DIM       = 3;

  localparam int NB_NUM      = 8;
  localparam int NB_CNT_W    = 4;
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  localparam int STEP_FIRST_CAP = 2;
  localparam int STEP_WR_START  = 4;
  localparam int STEP_WRAP_OFS  = 2;
  localparam int STEP_END_OFS   = 3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  row_index;
    logic [63:0] row_bits;
  } req_t;

  typedef struct packed {
    logic [63:0] row_out;
    logic        done_res;
  } rsp_t;

  typedef struct packed {
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] mid;
    logic [ROW_W-1:0] dn;
  } row_window_t;

  function automatic logic [ROW_CNT_W-1:0] bound_rows(input logic [CFG_W-1:0] v);
    logic [ROW_CNT_W-1:0] res;
    if (int'(v) < MIN_DIM) begin
      res = ROW_CNT_W'(MIN_DIM);
    end else if (int'(v) > MAX_ROWS) begin
      res = ROW_CNT_W'(MAX_ROWS);
    end else begin
      res = ROW_CNT_W'(v);
    end
    return res;
  endfunction

  function automatic logic [COL_CNT_W-1:0] bound_cols(input logic [CFG_W-1:0] v);
    logic [COL_CNT_W-1:0] res;
    if (int'(v) < MIN_DIM) begin
      res = COL_CNT_W'(MIN_DIM);
    end else if (int'(v) > MAX_COLS) begin
      res = COL_CNT_W'(MAX_COLS);
    end else begin
      res = COL_CNT_W'(v);
    end
    return res;
  endfunction

endpackage

// ===== src/lg_cell_lane.sv =====
// One cell of the B3/S23 rule: counts eight neighbours and gives the next state.
module lg_cell_lane (
  input  logic [lg_pkg::NB_NUM-1:0] nb,
  input  logic                      alive,
  output logic                      next_alive
);

  logic [lg_pkg::NB_CNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < lg_pkg::NB_NUM; i++) begin
      cnt = cnt + lg_pkg::NB_CNT_W'(nb[i]);
    end
    next_alive = (cnt == lg_pkg::NB_CNT_W'(lg_pkg::BIRTH_COUNT)) ||
                 ((cnt == lg_pkg::NB_CNT_W'(lg_pkg::KEEP_COUNT)) && alive);
  end

endmodule

// ===== src/lg_row_engine.sv =====
// Row engine: one lane per column with column wrap, merged under the used-column mask.
module lg_row_engine (
  input  lg_pkg::row_window_t            win,
  input  logic [lg_pkg::COL_CNT_W-1:0]   ncols,
  output logic [lg_pkg::ROW_W-1:0]       next_row
);

  logic [lg_pkg::BIT_IDX_W-1:0] last;
  logic [lg_pkg::ROW_W-1:0]     up_l, up_r, mid_l, mid_r, dn_l, dn_r;
  logic [lg_pkg::ROW_W-1:0]     col_mask;
  logic [lg_pkg::ROW_W-1:0]     lane_out;

  assign last = lg_pkg::BIT_IDX_W'(ncols - lg_pkg::COL_CNT_W'(1));

  always_comb begin
    up_l  = {win.up[lg_pkg::ROW_W-2:0], win.up[last]};
    mid_l = {win.mid[lg_pkg::ROW_W-2:0], win.mid[last]};
    dn_l  = {win.dn[lg_pkg::ROW_W-2:0], win.dn[last]};
    up_r  = {win.up[0], win.up[lg_pkg::ROW_W-1:1]};
    mid_r = {win.mid[0], win.mid[lg_pkg::ROW_W-1:1]};
    dn_r  = {win.dn[0], win.dn[lg_pkg::ROW_W-1:1]};
    up_r[last]  = win.up[0];
    mid_r[last] = win.mid[0];
    dn_r[last]  = win.dn[0];
    for (int c = 0; c < lg_pkg::ROW_W; c++) begin
      col_mask[c] = (c < int'(ncols));
    end
  end

  for (genvar c = 0; c < lg_pkg::ROW_W; c++) begin : g_lane
    lg_cell_lane u_lane (
      .nb        ({up_l[c], win.up[c], up_r[c], mid_l[c], mid_r[c],
                   dn_l[c], win.dn[c], dn_r[c]}),
      .alive     (win.mid[c]),
      .next_alive(lane_out[c])
    );
  end

  assign next_row = (lane_out & col_mask) | (win.mid & ~col_mask);

endmodule

// ===== src/life_generation_toroidal_top.sv =====
// Top level of the toroidal Life grid: grid memory, generation sequencer and result register.
//
// The block stores a 64 by 64 cell grid in a one-write, one-read memory whose rows carry
// valid bits, so the grid reads as all dead straight after reset with no clearing pass.
// A write or read request passes from idle through the finish state before the next request
// can be taken. A generation step covers the used row count, which is rows_used clamped to
// between 3 and 64: the single read port streams one row per cycle into a three-row window,
// the 64 column lanes compute one new row per cycle from that window and write it back in
// place, and the old first row is held aside for the wrap at the bottom edge. The result
// register lets the next request be taken while a finished result still waits for its
// transfer.
module life_generation_toroidal_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  lg_pkg::req_t                   req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output lg_pkg::rsp_t                   rsp,
  input  logic                           cfg_we,
  input  logic [lg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lg_pkg::CFG_W-1:0]       cfg_wdata
);

  logic [lg_pkg::ROW_W-1:0]       grid_mem [lg_pkg::MAX_ROWS];
  logic [lg_pkg::MAX_ROWS-1:0]    row_valid;
  logic [lg_pkg::ROW_W-1:0]       rd_q;
  logic                           rd_q_valid;
  logic [lg_pkg::ROW_W-1:0]       rd_row;

  logic [lg_pkg::CFG_W-1:0]       rows_used;
  logic [lg_pkg::CFG_W-1:0]       cols_used;
  logic [lg_pkg::ROW_CNT_W-1:0]   nrows;
  logic [lg_pkg::COL_CNT_W-1:0]   ncols;

  lg_pkg::state_t                 state, state_next;
  logic [lg_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic [lg_pkg::STEP_CNT_W-1:0]  step_rows;
  logic [lg_pkg::STEP_CNT_W-1:0]  step_end;

  lg_pkg::row_window_t            win;
  logic [lg_pkg::ROW_W-1:0]       first_row;
  logic [lg_pkg::ROW_W-1:0]       new_row;

  logic [1:0]                     cur_act;
  logic                           cur_ok;
  logic                           req_fire;
  logic                           req_in_range;

  logic                           rd_en;
  logic [lg_pkg::ROW_AW-1:0]      rd_addr;
  logic                           mem_we;
  logic [lg_pkg::ROW_AW-1:0]      wr_addr;
  logic [lg_pkg::ROW_W-1:0]       wr_data;
  logic                           shift_mem;
  logic                           shift_first;
  logic                           cap_first;
  logic                           fin_load;

  assign nrows     = lg_pkg::bound_rows(rows_used);
  assign ncols     = lg_pkg::bound_cols(cols_used);
  assign step_rows = lg_pkg::STEP_CNT_W'(nrows);
  assign step_end  = step_rows + lg_pkg::STEP_CNT_W'(lg_pkg::STEP_END_OFS);
  assign rd_row    = rd_q_valid ? rd_q : '0;
  assign req_fire  = req_valid && req_ready;
  assign req_in_range = int'(req.row_index) < lg_pkg::MAX_ROWS;

  lg_row_engine u_engine (
    .win     (win),
    .ncols   (ncols),
    .next_row(new_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      lg_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == lg_pkg::ACT_STEP) ? lg_pkg::ST_STEP : lg_pkg::ST_FINISH;
        end
      end
      lg_pkg::ST_STEP: begin
        if (step_cnt == step_end) begin
          state_next = lg_pkg::ST_FINISH;
        end
      end
      lg_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = lg_pkg::ST_IDLE;
        end
      end
      default: state_next = lg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = lg_pkg::ROW_AW'(req.row_index);
    mem_we      = 1'b0;
    wr_addr     = lg_pkg::ROW_AW'(req.row_index);
    wr_data     = req.row_bits;
    shift_mem   = 1'b0;
    shift_first = 1'b0;
    cap_first   = 1'b0;
    fin_load    = 1'b0;
    case (state)
      lg_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        rd_en     = req_valid && (req.action == lg_pkg::ACT_READ) && req_in_range;
        mem_we    = req_valid && (req.action == lg_pkg::ACT_WRITE) && req_in_range;
      end
      lg_pkg::ST_STEP: begin
        rd_en = step_cnt <= step_rows;
        if (step_cnt == '0) begin
          rd_addr = lg_pkg::ROW_AW'(nrows - lg_pkg::ROW_CNT_W'(1));
        end else begin
          rd_addr = lg_pkg::ROW_AW'(step_cnt - lg_pkg::STEP_CNT_W'(1));
        end
        shift_mem   = (step_cnt != '0) && (step_cnt <= step_rows + lg_pkg::STEP_CNT_W'(1));
        shift_first = step_cnt == step_rows + lg_pkg::STEP_CNT_W'(lg_pkg::STEP_WRAP_OFS);
        cap_first   = step_cnt == lg_pkg::STEP_CNT_W'(lg_pkg::STEP_FIRST_CAP);
        mem_we      = step_cnt >= lg_pkg::STEP_CNT_W'(lg_pkg::STEP_WR_START);
        wr_addr     = lg_pkg::ROW_AW'(step_cnt - lg_pkg::STEP_CNT_W'(lg_pkg::STEP_WR_START));
        wr_data     = new_row;
      end
      lg_pkg::ST_FINISH: begin
        fin_load = !rsp_valid || rsp_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= grid_mem[rd_addr];
      rd_q_valid <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lg_pkg::ST_IDLE;
      step_cnt  <= '0;
      rsp_valid <= 1'b0;
      row_valid <= '0;
      rows_used <= lg_pkg::CFG_W'(lg_pkg::CFG_DIM_RESET);
      cols_used <= lg_pkg::CFG_W'(lg_pkg::CFG_DIM_RESET);
    end else begin
      state    <= state_next;
      step_cnt <= (state == lg_pkg::ST_STEP) ? step_cnt + lg_pkg::STEP_CNT_W'(1) : '0;
      if (mem_we) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (fin_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          lg_pkg::CFG_ROWS: rows_used <= cfg_wdata;
          lg_pkg::CFG_COLS: cols_used <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_act <= req.action;
      cur_ok  <= req_in_range;
    end
    if (shift_mem) begin
      win <= '{up: win.mid, mid: win.dn, dn: rd_row};
    end else if (shift_first) begin
      win <= '{up: win.mid, mid: win.dn, dn: first_row};
    end
    if (cap_first) begin
      first_row <= rd_row;
    end
    if (fin_load) begin
      rsp.row_out  <= ((cur_act == lg_pkg::ACT_READ) && cur_ok) ? rd_row : '0;
      rsp.done_res <= (cur_act == lg_pkg::ACT_WRITE) || (cur_act == lg_pkg::ACT_STEP) ||
                      (cur_act == lg_pkg::ACT_READ);
    end
  end

`ifndef ASSERT_OFF
  a_step_write_in_rows: assert property (@(posedge clk) disable iff (rst)
    (state == lg_pkg::ST_STEP && mem_we) |-> (int'(wr_addr) < int'(nrows)))
    else $error("Generation write outside the used rows.");

  a_step_ports_apart: assert property (@(posedge clk) disable iff (rst)
    (state == lg_pkg::ST_STEP && mem_we && rd_en) |-> (rd_addr != wr_addr))
    else $error("Generation reads and writes the same row in one cycle.");

  a_short_to_finish: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.action != lg_pkg::ACT_STEP) |=> (state == lg_pkg::ST_FINISH))
    else $error("Write, read or unknown request did not go straight to finish.");

  a_step_ends: assert property (@(posedge clk) disable iff (rst)
    (state == lg_pkg::ST_STEP && step_cnt == step_end) |=> (state == lg_pkg::ST_FINISH))
    else $error("Generation did not end on schedule.");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == lg_pkg::ST_FINISH))
    else $error("Result raised outside the finish state.");
`endif

endmodule
